// ===== design/rpe_pkg.sv =====
// Shared types and codes for the rectangle placement engine.
// No dependencies; rpe_cell, the engine and the testbench import this package.
package rpe_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_REC,
		S_DIV,
		S_CHK,
		S_COL,
		S_ROW,
		S_WAIT,
		S_WAIT_MAN,
		S_FIN
	} state_t;

	// control bits travelling with a query along the cell chain
	typedef struct packed {
		logic vld;
		logic cand;
		logic hit;
	} qctl_t;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_MANUAL = 2'd1;
	localparam logic [1:0] OP_AUTO   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [3:0] STAT_PLACED   = 4'd0;
	localparam logic [3:0] STAT_AREA     = 4'd1;
	localparam logic [3:0] STAT_OUTSIDE  = 4'd2;
	localparam logic [3:0] STAT_OVERLAP  = 4'd3;
	localparam logic [3:0] STAT_WIDTH    = 4'd4;
	localparam logic [3:0] STAT_HEIGHT   = 4'd5;
	localparam logic [3:0] STAT_NOSPOT   = 4'd6;
	localparam logic [3:0] STAT_RECORDED = 4'd7;
	localparam logic [3:0] STAT_FULL     = 4'd8;

	localparam logic [2:0] CFG_AREA_LEFT   = 3'd0;
	localparam logic [2:0] CFG_AREA_TOP    = 3'd1;
	localparam logic [2:0] CFG_AREA_RIGHT  = 3'd2;
	localparam logic [2:0] CFG_AREA_BOTTOM = 3'd3;
	localparam logic [2:0] CFG_SPACING     = 3'd4;
	localparam logic [2:0] CFG_DEF_WIDTH   = 3'd5;

	localparam int RST_AREA_RIGHT  = 1920;
	localparam int RST_AREA_BOTTOM = 1080;
	localparam int RST_SPACING     = 8;
	localparam int RST_DEF_WIDTH   = 320;

	// height cap is floor(area height * 3 / 5)
	localparam logic [4:0] CAP_DIVISOR = 5'd5;

endpackage

// ===== design/rpe_item_if.sv =====
// Request channel of the rectangle placement engine.
// Carries valid, ready and one request; depends on nothing.
interface rpe_item_if #(parameter int CoordBits = 16);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [15:0]                 item_tag;
	logic signed [CoordBits-1:0] rect_left;
	logic signed [CoordBits-1:0] rect_top;
	logic signed [CoordBits-1:0] rect_right;
	logic signed [CoordBits-1:0] rect_bottom;
	logic signed [CoordBits-1:0] req_width;
	logic signed [CoordBits-1:0] req_height;

	modport source (output valid, opcode, item_tag, rect_left, rect_top, rect_right,
		rect_bottom, req_width, req_height, input ready);
	modport sink (input valid, opcode, item_tag, rect_left, rect_top, rect_right,
		rect_bottom, req_width, req_height, output ready);
endinterface

// ===== design/rpe_result_if.sv =====
// Result channel of the rectangle placement engine.
// Carries valid, ready and one result; depends on nothing.
interface rpe_result_if #(parameter int CoordBits = 16);
	logic                        valid;
	logic                        ready;
	logic [15:0]                 tag_out;
	logic                        placed;
	logic [3:0]                  status;
	logic signed [CoordBits-1:0] out_left;
	logic signed [CoordBits-1:0] out_top;
	logic signed [CoordBits-1:0] out_right;
	logic signed [CoordBits-1:0] out_bottom;
	logic                        scroll_needed;

	modport source (output valid, tag_out, placed, status, out_left, out_top, out_right,
		out_bottom, scroll_needed, input ready);
	modport sink (input valid, tag_out, placed, status, out_left, out_top, out_right,
		out_bottom, scroll_needed, output ready);
endinterface

// ===== design/rpe_cell.sv =====
// One store cell: holds a single stored rectangle and its occupied and width flags, tests the
// passing query against it and hands the query on. Uses rpe_pkg.
module rpe_cell #(
	parameter int Idx       = 0,
	parameter int CoordBits = 16,
	parameter int CntBits   = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [CntBits-1:0]          cnt,
	input  logic                        wr_en,
	input  logic                        wr_occ,
	input  logic                        wr_wid,
	input  logic signed [CoordBits-1:0] wr_left,
	input  logic signed [CoordBits-1:0] wr_top,
	input  logic signed [CoordBits-1:0] wr_right,
	input  logic signed [CoordBits-1:0] wr_bottom,
	input  logic signed [CoordBits+2:0] gap,
	input  rpe_pkg::qctl_t              ctl_i,
	input  logic signed [CoordBits+2:0] ql_i,
	input  logic signed [CoordBits+2:0] qt_i,
	input  logic signed [CoordBits+2:0] qr_i,
	input  logic signed [CoordBits+2:0] qb_i,
	input  logic signed [CoordBits+2:0] qw_i,
	input  logic signed [CoordBits+2:0] qnext_i,
	input  logic [CntBits-1:0]          qn_i,
	output rpe_pkg::qctl_t              ctl_o,
	output logic signed [CoordBits+2:0] ql_o,
	output logic signed [CoordBits+2:0] qt_o,
	output logic signed [CoordBits+2:0] qr_o,
	output logic signed [CoordBits+2:0] qb_o,
	output logic signed [CoordBits+2:0] qw_o,
	output logic signed [CoordBits+2:0] qnext_o,
	output logic [CntBits-1:0]          qn_o
);
	import rpe_pkg::*;

	localparam int CW = CoordBits + 3;

	logic signed [CoordBits-1:0] el_q, et_q, er_q, eb_q;
	logic signed [CW-1:0]        ew_q;
	logic                        occ_q, wid_q;

	logic                 live, hit, match;
	logic signed [CW-1:0] bg;

	qctl_t                ctl_s1;
	logic signed [CW-1:0] ql_s1, qt_s1, qr_s1, qb_s1, qw_s1, qnext_s1;
	logic [CntBits-1:0]   qn_s1;

	always_ff @(posedge clk) begin
		if (wr_en && cnt == CntBits'(Idx)) begin
			el_q  <= wr_left;
			et_q  <= wr_top;
			er_q  <= wr_right;
			eb_q  <= wr_bottom;
			ew_q  <= CW'(wr_right) - CW'(wr_left);
			occ_q <= wr_occ;
			wid_q <= wr_wid;
		end
	end

	always_comb begin
		live  = CntBits'(Idx) < cnt;
		hit   = live && occ_q && (ql_i < CW'(er_q)) && (qr_i > CW'(el_q))
			&& (qt_i < CW'(eb_q)) && (qb_i > CW'(et_q));
		bg    = CW'(eb_q) + gap;
		match = live && wid_q && (ew_q == qw_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= ctl_i.vld;
			ctl_s1.cand <= ctl_i.cand;
			ctl_s1.hit  <= ctl_i.hit | hit;
		end
	end

	always_ff @(posedge clk) begin
		ql_s1    <= ql_i;
		qt_s1    <= qt_i;
		qr_s1    <= qr_i;
		qb_s1    <= qb_i;
		qw_s1    <= qw_i;
		qnext_s1 <= (hit && bg > qnext_i) ? bg : qnext_i;
		qn_s1    <= qn_i + CntBits'(match);
	end

	assign ctl_o   = ctl_s1;
	assign ql_o    = ql_s1;
	assign qt_o    = qt_s1;
	assign qr_o    = qr_s1;
	assign qb_o    = qb_s1;
	assign qw_o    = qw_s1;
	assign qnext_o = qnext_s1;
	assign qn_o    = qn_s1;

endmodule

// ===== design/rect_placement_engine.sv =====
// Rectangle placement engine: sequencer, width table and the chain of store cells.
// Uses rpe_pkg, rpe_item_if, rpe_result_if and rpe_cell.
//
// One request is worked on at a time; a finished result waits in an output
// register while the next request is taken. Every lookup of the store is a
// query that walks the chain of MaxRects cells, one cell per cycle. A record
// and an ignored request send no query; a manual placement sends one. An
// automatic placement, when no width is requested and the store holds
// entries, first sends one query per entry to find the most common width,
// then works out the height cap, then sends a query for each trial position
// of the column search, moving to the next column when a column is used up.
module rect_placement_engine #(
	parameter int MaxRects  = 64,
	parameter int CoordBits = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rpe_item_if.sink              item,
	rpe_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [CoordBits-1:0]  cfg_wdata
);
	import rpe_pkg::*;

	localparam int CW   = CoordBits + 3;
	localparam int CNTW = $clog2(MaxRects + 1);
	localparam int IDXW = $clog2(MaxRects);
	localparam int DB   = CoordBits + 2;
	// reciprocal of the cap divisor, exact for every dividend below 2**DB
	localparam int RSH  = DB + 2;
	localparam logic [DB-1:0] RCP = DB'(((longint'(1) << RSH) / longint'(CAP_DIVISOR)) + 1);

	state_t state_q, state_d;

	logic signed [CoordBits-1:0] area_l_q, area_t_q, area_r_q, area_b_q, spacing_q, defw_q;
	logic [CNTW-1:0]             cnt_q;

	logic [1:0]           op_q;
	logic [15:0]          tag_q;
	logic signed [CW-1:0] rl_q, rt_q, rr_q, rb_q, rw_q, des_q;
	logic signed [CW-1:0] width_q, height_q, right_q, top_q, best_q;
	logic [CNTW-1:0]      bestn_q, iss_q, ret_q;
	logic                 mrd_vld_s1, rdc_s1;
	logic signed [CW-1:0] rdw_s1;
	logic [DB-1:0]        div_x_q;

	logic [CW:0] wmem_q [MaxRects];

	qctl_t                inj_ctl_q;
	logic signed [CW-1:0] inj_l_q, inj_t_q, inj_r_q, inj_b_q, inj_w_q, inj_next_q;

	logic [3:0]                  res_status_q;
	logic                        res_placed_q, res_scroll_q;
	logic signed [CoordBits-1:0] res_l_q, res_t_q, res_r_q, res_b_q;

	logic                        out_vld_q;
	logic [15:0]                 o_tag_q;
	logic [3:0]                  o_status_q;
	logic                        o_placed_q, o_scroll_q;
	logic signed [CoordBits-1:0] o_l_q, o_t_q, o_r_q, o_b_q;

	qctl_t                ctl_w   [MaxRects+1];
	logic signed [CW-1:0] l_w     [MaxRects+1];
	logic signed [CW-1:0] t_w     [MaxRects+1];
	logic signed [CW-1:0] r_w     [MaxRects+1];
	logic signed [CW-1:0] b_w     [MaxRects+1];
	logic signed [CW-1:0] w_w     [MaxRects+1];
	logic signed [CW-1:0] next_w  [MaxRects+1];
	logic [CNTW-1:0]      n_w     [MaxRects+1];

	logic signed [CW-1:0] a_l, a_t, a_r, a_b, gap_c, gap2_c, defw_c, aw_c, ah_c;
	logic signed [CW-1:0] maxh_c, h_c, trial_l, trial_b;
	logic signed [CoordBits-1:0] wb_l, wb_t, wb_r, wb_b;
	logic        area_ok, rect_ok, in_area, full, col_ok, row_ok, better, size_bad;
	logic [2*DB-1:0] div_p;
	logic        out_load;

	logic       fin_en, fin_placed, fin_scroll;
	logic [3:0] fin_status;
	logic       wr_en, wr_occ, wr_wid, inj_en, inj_man;
	logic       rec_init, rec_iss, rec_ret, div_init, chk_set, row_init, col_step, top_adv;
	logic       width_from_req, width_from_def, width_from_best;

	always_comb begin
		a_l     = CW'(area_l_q);
		a_t     = CW'(area_t_q);
		a_r     = CW'(area_r_q);
		a_b     = CW'(area_b_q);
		gap_c   = spacing_q[CoordBits-1] ? '0 : CW'(spacing_q);
		gap2_c  = gap_c + gap_c;
		defw_c  = (defw_q < 1) ? CW'(1) : CW'(defw_q);
		aw_c    = a_r - a_l;
		ah_c    = a_b - a_t;
		area_ok = (a_r > a_l) && (a_b > a_t);
		rect_ok = (rr_q > rl_q) && (rb_q > rt_q);
		in_area = (rl_q >= a_l) && (rt_q >= a_t) && (rr_q <= a_r) && (rb_q <= a_b);
		full    = cnt_q >= CNTW'(MaxRects);
		maxh_c  = signed'(CW'(div_x_q));
		h_c     = (des_q < maxh_c) ? des_q : maxh_c;
		size_bad = (width_q <= 0) || (des_q <= 0) || (maxh_c <= 0) || (width_q + gap2_c > aw_c);
		trial_l = right_q - width_q;
		trial_b = top_q + height_q;
		col_ok  = trial_l >= a_l + gap_c;
		row_ok  = trial_b <= a_b - gap_c;
		better  = ctl_w[MaxRects].cand && ((n_w[MaxRects] > bestn_q)
			|| (n_w[MaxRects] == bestn_q && w_w[MaxRects] < best_q));
		div_p   = (2*DB)'(div_x_q) * (2*DB)'(RCP);
		if (op_q == OP_AUTO) begin
			wb_l = CoordBits'(trial_l);
			wb_t = CoordBits'(top_q);
			wb_r = CoordBits'(right_q);
			wb_b = CoordBits'(trial_b);
		end else begin
			wb_l = CoordBits'(rl_q);
			wb_t = CoordBits'(rt_q);
			wb_r = CoordBits'(rr_q);
			wb_b = CoordBits'(rb_q);
		end
		out_load = (state_q == S_FIN) && (!out_vld_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		fin_en          = 1'b0;
		fin_status      = STAT_PLACED;
		fin_placed      = 1'b0;
		fin_scroll      = 1'b0;
		wr_en           = 1'b0;
		wr_occ          = 1'b0;
		wr_wid          = 1'b0;
		inj_en          = 1'b0;
		inj_man         = 1'b0;
		rec_init        = 1'b0;
		rec_iss         = 1'b0;
		rec_ret         = 1'b0;
		div_init        = 1'b0;
		chk_set         = 1'b0;
		row_init        = 1'b0;
		col_step        = 1'b0;
		top_adv         = 1'b0;
		width_from_req  = 1'b0;
		width_from_def  = 1'b0;
		width_from_best = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item.valid && item.opcode != OP_NONE) state_d = S_DEC;
			end
			S_DEC: begin
				if (op_q == OP_RECORD) begin
					fin_en     = 1'b1;
					fin_status = STAT_RECORDED;
					state_d    = S_FIN;
					if (rr_q > rl_q) begin
						if (full) begin
							fin_status = STAT_FULL;
						end else begin
							wr_en  = 1'b1;
							wr_occ = rect_ok;
							wr_wid = 1'b1;
						end
					end
				end else if (!area_ok) begin
					fin_en     = 1'b1;
					fin_status = STAT_AREA;
					state_d    = S_FIN;
				end else if (op_q == OP_MANUAL) begin
					if (!rect_ok || !in_area) begin
						fin_en     = 1'b1;
						fin_status = STAT_OUTSIDE;
						state_d    = S_FIN;
					end else begin
						inj_en  = 1'b1;
						inj_man = 1'b1;
						state_d = S_WAIT_MAN;
					end
				end else if (rw_q > 0) begin
					width_from_req = 1'b1;
					div_init       = 1'b1;
					state_d        = S_DIV;
				end else if (cnt_q == '0) begin
					width_from_def = 1'b1;
					div_init       = 1'b1;
					state_d        = S_DIV;
				end else begin
					rec_init = 1'b1;
					state_d  = S_REC;
				end
			end
			S_REC: begin
				if (ret_q == cnt_q) begin
					width_from_best = 1'b1;
					div_init        = 1'b1;
					state_d         = S_DIV;
				end else begin
					rec_iss = iss_q < cnt_q;
					rec_ret = ctl_w[MaxRects].vld;
				end
			end
			S_DIV: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (size_bad) begin
					fin_en     = 1'b1;
					fin_status = STAT_WIDTH;
					state_d    = S_FIN;
				end else if (h_c + gap2_c > ah_c) begin
					fin_en     = 1'b1;
					fin_status = STAT_HEIGHT;
					state_d    = S_FIN;
				end else begin
					chk_set = 1'b1;
					state_d = S_COL;
				end
			end
			S_COL: begin
				if (col_ok) begin
					row_init = 1'b1;
					state_d  = S_ROW;
				end else begin
					fin_en     = 1'b1;
					fin_status = STAT_NOSPOT;
					state_d    = S_FIN;
				end
			end
			S_ROW: begin
				if (row_ok) begin
					inj_en  = 1'b1;
					state_d = S_WAIT;
				end else begin
					col_step = 1'b1;
					state_d  = S_COL;
				end
			end
			S_WAIT: begin
				if (ctl_w[MaxRects].vld) begin
					if (next_w[MaxRects] == top_q) begin
						fin_en  = 1'b1;
						state_d = S_FIN;
						if (full) begin
							fin_status = STAT_FULL;
						end else begin
							wr_en      = 1'b1;
							wr_occ     = 1'b1;
							fin_placed = 1'b1;
							fin_scroll = des_q > height_q;
						end
					end else begin
						top_adv = 1'b1;
						state_d = S_ROW;
					end
				end
			end
			S_WAIT_MAN: begin
				if (ctl_w[MaxRects].vld) begin
					fin_en  = 1'b1;
					state_d = S_FIN;
					if (ctl_w[MaxRects].hit) begin
						fin_status = STAT_OVERLAP;
					end else if (full) begin
						fin_status = STAT_FULL;
					end else begin
						wr_en      = 1'b1;
						wr_occ     = 1'b1;
						fin_placed = 1'b1;
					end
				end
			end
			S_FIN: begin
				if (!out_vld_q || result.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_l_q   <= '0;
			area_t_q   <= '0;
			area_r_q   <= CoordBits'(RST_AREA_RIGHT);
			area_b_q   <= CoordBits'(RST_AREA_BOTTOM);
			spacing_q  <= CoordBits'(RST_SPACING);
			defw_q     <= CoordBits'(RST_DEF_WIDTH);
			cnt_q      <= '0;
			mrd_vld_s1 <= 1'b0;
			inj_ctl_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_AREA_LEFT:   area_l_q  <= cfg_wdata;
					CFG_AREA_TOP:    area_t_q  <= cfg_wdata;
					CFG_AREA_RIGHT:  area_r_q  <= cfg_wdata;
					CFG_AREA_BOTTOM: area_b_q  <= cfg_wdata;
					CFG_SPACING:     spacing_q <= cfg_wdata;
					CFG_DEF_WIDTH:   defw_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (wr_en) cnt_q <= cnt_q + CNTW'(1);
			mrd_vld_s1     <= rec_iss;
			inj_ctl_q.vld  <= inj_en | mrd_vld_s1;
			inj_ctl_q.cand <= mrd_vld_s1 & rdc_s1;
			inj_ctl_q.hit  <= 1'b0;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q  <= item.opcode;
			tag_q <= item.item_tag;
			rl_q  <= CW'(item.rect_left);
			rt_q  <= CW'(item.rect_top);
			rr_q  <= CW'(item.rect_right);
			rb_q  <= CW'(item.rect_bottom);
			rw_q  <= CW'(item.req_width);
			des_q <= CW'(item.req_height);
		end
		if (wr_en) wmem_q[cnt_q[IDXW-1:0]] <= {wr_wid, rr_q - rl_q};
		if (rec_iss) {rdc_s1, rdw_s1} <= wmem_q[iss_q[IDXW-1:0]];
		if (rec_init) begin
			best_q  <= defw_c;
			bestn_q <= '0;
			iss_q   <= '0;
			ret_q   <= '0;
		end else begin
			if (rec_iss) iss_q <= iss_q + CNTW'(1);
			if (rec_ret) begin
				ret_q <= ret_q + CNTW'(1);
				if (better) begin
					best_q  <= w_w[MaxRects];
					bestn_q <= n_w[MaxRects];
				end
			end
		end
		if (width_from_req) width_q <= rw_q;
		if (width_from_def) width_q <= defw_c;
		if (width_from_best) width_q <= best_q;
		if (div_init) begin
			div_x_q <= DB'(ah_c + ah_c + ah_c);
		end else if (state_q == S_DIV) begin
			div_x_q <= DB'(div_p >> RSH);
		end
		if (chk_set) begin
			height_q <= h_c;
			right_q  <= a_r - gap_c;
		end
		if (col_step) right_q <= right_q - (width_q + gap_c);
		if (row_init) top_q <= a_t + gap_c;
		if (top_adv) top_q <= next_w[MaxRects];
		if (inj_en) begin
			inj_l_q    <= inj_man ? rl_q : trial_l;
			inj_t_q    <= inj_man ? rt_q : top_q;
			inj_r_q    <= inj_man ? rr_q : right_q;
			inj_b_q    <= inj_man ? rb_q : trial_b;
			inj_w_q    <= '0;
			inj_next_q <= top_q;
		end else if (mrd_vld_s1) begin
			inj_w_q <= rdw_s1;
		end
		if (fin_en) begin
			res_status_q <= fin_status;
			res_placed_q <= fin_placed;
			res_scroll_q <= fin_scroll;
			res_l_q      <= fin_placed ? wb_l : '0;
			res_t_q      <= fin_placed ? wb_t : '0;
			res_r_q      <= fin_placed ? wb_r : '0;
			res_b_q      <= fin_placed ? wb_b : '0;
		end
		if (out_load) begin
			o_tag_q    <= tag_q;
			o_status_q <= res_status_q;
			o_placed_q <= res_placed_q;
			o_scroll_q <= res_scroll_q;
			o_l_q      <= res_l_q;
			o_t_q      <= res_t_q;
			o_r_q      <= res_r_q;
			o_b_q      <= res_b_q;
		end
	end

	assign ctl_w[0]  = inj_ctl_q;
	assign l_w[0]    = inj_l_q;
	assign t_w[0]    = inj_t_q;
	assign r_w[0]    = inj_r_q;
	assign b_w[0]    = inj_b_q;
	assign w_w[0]    = inj_w_q;
	assign next_w[0] = inj_next_q;
	assign n_w[0]    = '0;

	for (genvar g = 0; g < MaxRects; g++) begin : g_cell
		rpe_cell #(
			.Idx       (g),
			.CoordBits (CoordBits),
			.CntBits   (CNTW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cnt       (cnt_q),
			.wr_en     (wr_en),
			.wr_occ    (wr_occ),
			.wr_wid    (wr_wid),
			.wr_left   (wb_l),
			.wr_top    (wb_t),
			.wr_right  (wb_r),
			.wr_bottom (wb_b),
			.gap       (gap_c),
			.ctl_i     (ctl_w[g]),
			.ql_i      (l_w[g]),
			.qt_i      (t_w[g]),
			.qr_i      (r_w[g]),
			.qb_i      (b_w[g]),
			.qw_i      (w_w[g]),
			.qnext_i   (next_w[g]),
			.qn_i      (n_w[g]),
			.ctl_o     (ctl_w[g+1]),
			.ql_o      (l_w[g+1]),
			.qt_o      (t_w[g+1]),
			.qr_o      (r_w[g+1]),
			.qb_o      (b_w[g+1]),
			.qw_o      (w_w[g+1]),
			.qnext_o   (next_w[g+1]),
			.qn_o      (n_w[g+1])
		);
	end

	assign item.ready           = (state_q == S_IDLE);
	assign result.valid         = out_vld_q;
	assign result.tag_out       = o_tag_q;
	assign result.placed        = o_placed_q;
	assign result.status        = o_status_q;
	assign result.out_left      = o_l_q;
	assign result.out_top       = o_t_q;
	assign result.out_right     = o_r_q;
	assign result.out_bottom    = o_b_q;
	assign result.scroll_needed = o_scroll_q;

	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> cnt_q < CNTW'(MaxRects))
		else $error("store write with no free entry");

	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> cnt_q == $past(cnt_q) + CNTW'(1))
		else $error("entry count did not advance on store write");

	a_next_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && ctl_w[MaxRects].vld) |-> next_w[MaxRects] >= top_q)
		else $error("search moved upwards");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && state_d == S_IDLE) |=> out_vld_q)
		else $error("finished request produced no result");

endmodule

// ===== tb/tb_rect_placement_engine.sv =====
// Self-checking testbench for rect_placement_engine: directed table, random requests, then random phases.
// Depends on rpe_pkg, rpe_item_if, rpe_result_if and the engine RTL.
// Typed table rows are checked against their table outcome, all others against a behavioural predictor.
module tb_rect_placement_engine;
	import rpe_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        tag;
		logic signed [15:0] l, t, r, b, rw, rh;
	} request_t;

	typedef struct {
		logic [15:0]        tag;
		logic               placed;
		logic [3:0]         status;
		logic signed [15:0] l, t, r, b;
		logic               scroll;
	} outcome_t;

	typedef struct {
		request_t rq;
		bit       typed;
		outcome_t ex;
	} plan_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = CFG_AREA_LEFT;
	logic [15:0] cfg_wdata = '0;

	rpe_item_if #(.CoordBits(16)) item_ch();
	rpe_result_if #(.CoordBits(16)) result_ch();

	rect_placement_engine #(.MaxRects(64), .CoordBits(16)) dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// predictor state
	longint area_l = 0, area_t = 0, area_r = RST_AREA_RIGHT, area_b = RST_AREA_BOTTOM;
	longint gap_cfg = RST_SPACING, def_w = RST_DEF_WIDTH;
	longint box_l[64], box_t[64], box_r[64], box_b[64];
	bit [1:0] box_f[64];
	int box_n = 0;

	outcome_t pending[$];
	int fails = 0;
	bit quiet = 0;

	function automatic bit box_hit(longint l, longint t, longint r, longint b, int i);
		return l < box_r[i] && r > box_l[i] && t < box_b[i] && b > box_t[i];
	endfunction

	function automatic bit store_hit(longint l, longint t, longint r, longint b);
		for (int i = 0; i < box_n; i++)
			if (box_f[i][0] && box_hit(l, t, r, b, i)) return 1;
		return 0;
	endfunction

	function automatic longint common_width();
		longint best, w;
		int best_n, n;
		best = def_w < 1 ? 1 : def_w;
		best_n = 0;
		for (int i = 0; i < box_n; i++) begin
			if (!box_f[i][1]) continue;
			w = box_r[i] - box_l[i];
			n = 0;
			for (int j = 0; j < box_n; j++)
				if (box_f[j][1] && box_r[j] - box_l[j] == w) n++;
			if (n > best_n || (n == best_n && w < best)) begin
				best = w;
				best_n = n;
			end
		end
		return best;
	endfunction

	function automatic bit keep_box(longint l, longint t, longint r, longint b, bit [1:0] f);
		if (box_n >= 64) return 0;
		box_l[box_n] = l; box_t[box_n] = t; box_r[box_n] = r; box_b[box_n] = b;
		box_f[box_n] = f;
		box_n++;
		return 1;
	endfunction

	function automatic bit predict_placement(request_t rq, output outcome_t o);
		longint l, t, r, b, gap, width, desired, ah, aw, maxh, height, right, top, nxt;
		longint sl, st, sr, sb;
		bit [1:0] f;
		bit found;
		o = '{tag: rq.tag, placed: 0, status: STAT_RECORDED, l: 0, t: 0, r: 0, b: 0,
			scroll: 0};
		if (rq.op == OP_NONE) return 0;
		l = rq.l; t = rq.t; r = rq.r; b = rq.b;
		gap = gap_cfg < 0 ? 0 : gap_cfg;
		if (rq.op == OP_RECORD) begin
			f = {r - l > 0, r > l && b > t};
			if (f != 0 && !keep_box(l, t, r, b, f)) o.status = STAT_FULL;
		end else if (!(area_r > area_l && area_b > area_t)) begin
			o.status = STAT_AREA;
		end else if (rq.op == OP_MANUAL) begin
			if (!(r > l && b > t) || l < area_l || t < area_t || r > area_r || b > area_b)
				o.status = STAT_OUTSIDE;
			else if (store_hit(l, t, r, b))
				o.status = STAT_OVERLAP;
			else if (!keep_box(l, t, r, b, 2'b01))
				o.status = STAT_FULL;
			else begin
				o.status = STAT_PLACED;
				o.placed = 1;
				o.l = l; o.t = t; o.r = r; o.b = b;
			end
		end else begin
			width = rq.rw > 0 ? longint'(rq.rw) : common_width();
			desired = rq.rh;
			ah = area_b - area_t;
			aw = area_r - area_l;
			maxh = (ah * 3) / 5;
			if (width <= 0 || desired <= 0 || maxh <= 0 || width + gap * 2 > aw) begin
				o.status = STAT_WIDTH;
			end else begin
				height = desired < maxh ? desired : maxh;
				if (height + gap * 2 > ah) begin
					o.status = STAT_HEIGHT;
				end else begin
					found = 0;
					for (right = area_r - gap; !found && right - width >= area_l + gap;
							right -= width + gap) begin
						top = area_t + gap;
						while (!found && top + height <= area_b - gap) begin
							nxt = top;
							for (int i = 0; i < box_n; i++)
								if (box_f[i][0] && box_hit(right - width, top, right,
										top + height, i) && box_b[i] + gap > nxt)
									nxt = box_b[i] + gap;
							if (nxt == top) begin
								found = 1;
								sl = right - width; st = top; sr = right; sb = top + height;
							end
							top = nxt;
						end
					end
					if (!found)
						o.status = STAT_NOSPOT;
					else if (!keep_box(sl, st, sr, sb, 2'b01))
						o.status = STAT_FULL;
					else begin
						o.status = STAT_PLACED;
						o.placed = 1;
						o.l = sl; o.t = st; o.r = sr; o.b = sb;
						o.scroll = desired > height;
					end
				end
			end
		end
		return 1;
	endfunction

	// result side: random stall bursts, then check every accepted result
	initial begin
		int stall;
		stall = 0;
		result_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 4);
			if (stall > 0) begin
				result_ch.ready <= 0;
				stall--;
			end else
				result_ch.ready <= 1;
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending.size() == 0) begin
				$error("result with tag %0h arrived with nothing expected", result_ch.tag_out);
				fails++;
			end else begin
				w = pending.pop_front();
				check_field("tag_out", w.tag, result_ch.tag_out);
				check_field("placed", w.placed, result_ch.placed);
				check_field("status", w.status, result_ch.status);
				check_field("out_left", w.l, result_ch.out_left);
				check_field("out_top", w.t, result_ch.out_top);
				check_field("out_right", w.r, result_ch.out_right);
				check_field("out_bottom", w.b, result_ch.out_bottom);
				check_field("scroll_needed", w.scroll, result_ch.scroll_needed);
			end
		end
	end

	// request side
	task automatic send_request(request_t rq, bit typed, outcome_t ex);
		outcome_t o;
		int idle;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			idle = $urandom_range(1, 4);
			item_ch.valid <= 0;
			repeat (idle) @(negedge clk);
		end
		item_ch.valid <= 1;
		item_ch.opcode <= rq.op;
		item_ch.item_tag <= rq.tag;
		item_ch.rect_left <= rq.l;
		item_ch.rect_top <= rq.t;
		item_ch.rect_right <= rq.r;
		item_ch.rect_bottom <= rq.b;
		item_ch.req_width <= rq.rw;
		item_ch.req_height <= rq.rh;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (predict_placement(rq, o)) begin
			if (typed) o = ex;
			pending.insert(pending.size(), o);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 0;
		while (pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, longint value);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= value[15:0];
		@(negedge clk);
		case (idx)
			CFG_AREA_LEFT:   area_l = value;
			CFG_AREA_TOP:    area_t = value;
			CFG_AREA_RIGHT:  area_r = value;
			CFG_AREA_BOTTOM: area_b = value;
			CFG_SPACING:     gap_cfg = value;
			default:         def_w = value;
		endcase
	endtask

	function automatic logic signed [15:0] clamp16(longint v);
		return v > 32767 ? 16'sd32767 : v < -32768 ? -16'sd32768 : v[15:0];
	endfunction

	function automatic request_t random_request();
		request_t rq;
		longint x, y, w, h, aw, ah;
		int pick;
		aw = area_r > area_l ? area_r - area_l : 400;
		ah = area_b > area_t ? area_b - area_t : 300;
		if (aw > 2000) aw = 2000;
		if (ah > 1200) ah = 1200;
		x = area_l + $urandom_range(0, aw);
		y = area_t + $urandom_range(0, ah);
		rq.tag = 16'($urandom);
		rq.rw = 0;
		rq.rh = 16'($urandom_range(1, ah));
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			rq.op = OP_NONE;
			rq.l = 16'($urandom); rq.t = 16'($urandom);
			rq.r = 16'($urandom); rq.b = 16'($urandom);
		end else if (pick < 30) begin
			rq.op = OP_RECORD;
			case ($urandom_range(0, 3))
				0: w = 80;
				1: w = 120;
				2: w = 160;
				default: w = 200;
			endcase
			h = $urandom_range(0, 9) == 0 ? -longint'($urandom_range(0, 20))
				: $urandom_range(20, 200);
			rq.l = clamp16(x); rq.t = clamp16(y);
			rq.r = clamp16(x + w); rq.b = clamp16(y + h);
		end else if (pick < 60) begin
			rq.op = OP_MANUAL;
			rq.l = clamp16(x); rq.t = clamp16(y);
			rq.r = clamp16(x + $urandom_range(1, 200)); rq.b = clamp16(y + $urandom_range(1, 200));
		end else if (pick < 95) begin
			rq.op = OP_AUTO;
			rq.l = 16'($urandom); rq.t = 16'($urandom);
			rq.r = 16'($urandom); rq.b = 16'($urandom);
			rq.rw = $urandom_range(0, 2) == 0 ? 16'sd0 : 16'($urandom_range(60, 300));
			if ($urandom_range(0, 5) == 0) rq.rh = 16'($urandom_range(ah, 4 * ah + 1));
		end else begin
			// noise over the full width of every field; a record keeps right <= left and a positive width is at least 60
			rq.op = 2'($urandom_range(0, 3));
			rq.l = 16'($urandom); rq.t = 16'($urandom);
			rq.r = 16'($urandom); rq.b = 16'($urandom);
			rq.rw = 16'($urandom); rq.rh = 16'($urandom);
			if (rq.op == OP_RECORD && rq.r > rq.l) rq.r = rq.l;
			if (rq.rw > 0 && rq.rw < 60) rq.rw = 60;
		end
		return rq;
	endfunction

	function automatic plan_row_t mk(logic [1:0] op, logic [15:0] tag, longint l, longint t,
			longint r, longint b, longint rw, longint rh, bit typed, logic [3:0] st,
			longint ol, longint ot, longint orr, longint ob, logic sc);
		plan_row_t p;
		p.rq = '{op: op, tag: tag, l: l[15:0], t: t[15:0], r: r[15:0], b: b[15:0],
			rw: rw[15:0], rh: rh[15:0]};
		p.typed = typed;
		p.ex = '{tag: tag, placed: st == STAT_PLACED, status: st, l: ol[15:0], t: ot[15:0],
			r: orr[15:0], b: ob[15:0], scroll: sc};
		return p;
	endfunction

	initial begin
		plan_row_t plan[$];
		outcome_t none;
		longint phase_cfg[6][6];
		int phase_items;
		none = '{default: '0};
		item_ch.valid = 0;
		item_ch.opcode = OP_NONE;
		item_ch.item_tag = 0;
		item_ch.rect_left = 0; item_ch.rect_top = 0;
		item_ch.rect_right = 0; item_ch.rect_bottom = 0;
		item_ch.req_width = 0; item_ch.req_height = 0;

		plan.insert(plan.size(), mk(OP_NONE, 16'h0001, 0, 0, 0, 0, 0, 0, 1'b0, STAT_PLACED,
			0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h0000, 0, 0, 0, 0, 0, 100, 1'b1, STAT_PLACED,
			1592, 8, 1912, 108, 1'b0));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h0002, 5, 5, 5, 20, 0, 0, 1'b1,
			STAT_RECORDED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_MANUAL, 16'h0003, -10, 0, 10, 10, 0, 0, 1'b1,
			STAT_OUTSIDE, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_MANUAL, 16'hffff, 0, 0, 100, 100, 0, 0, 1'b1,
			STAT_PLACED, 0, 0, 100, 100, 1'b0));
		plan.insert(plan.size(), mk(OP_MANUAL, 16'h0004, 50, 50, 150, 150, 0, 0, 1'b1,
			STAT_OVERLAP, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h0005, 0, 0, 0, 0, 100, 0, 1'b1, STAT_WIDTH,
			0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h0006, 0, 0, 0, 0, 32767, 50, 1'b1,
			STAT_WIDTH, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h0007, 0, 0, 0, 0, -32768, 2000, 1'b1,
			STAT_PLACED, 1592, 116, 1912, 764, 1'b1));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h0008, 32767, 32767, -32768, -32768, 0, 0,
			1'b1, STAT_RECORDED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h0009, -32768, 32767, 32767, -32768, 0, 0,
			1'b1, STAT_RECORDED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h000a, 0, 0, 0, 0, 0, 10, 1'b1, STAT_WIDTH,
			0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h000b, 200, 200, 280, 260, 0, 0, 1'b1,
			STAT_RECORDED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h000c, 300, 200, 380, 260, 0, 0, 1'b1,
			STAT_RECORDED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h000d, 0, 0, 0, 0, 0, 32767, 1'b0,
			STAT_PLACED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_MANUAL, 16'h000e, 1900, 1000, 1920, 1080, 0, 0, 1'b0,
			STAT_PLACED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_MANUAL, 16'h000f, 0, 0, 1920, 1080, 0, 0, 1'b1,
			STAT_OVERLAP, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_NONE, 16'hffff, -1, -1, -1, -1, -1, -1, 1'b0,
			STAT_PLACED, 0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_AUTO, 16'h0010, 0, 0, 0, 0, 1, 1, 1'b0, STAT_PLACED,
			0, 0, 0, 0, 1'b0));
		plan.insert(plan.size(), mk(OP_RECORD, 16'h0011, -1, 0, -32768, 5, 0, 0, 1'b1,
			STAT_RECORDED, 0, 0, 0, 0, 1'b0));

		phase_cfg = '{
			'{-32768, -32768, 32767, 32767, 0, -32768},
			'{100, 50, 700, 450, -5, 0},
			'{0, 0, 400, 100, 25, 32767},
			'{500, 0, 400, 300, 8, 200},
			'{-200, -300, 600, 500, 32767, 100},
			'{0, 0, 1920, 1080, 8, 320}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].ex);
		for (int n = 0; n < 440; n++) begin
			if (n == 220) drain();
			send_request(random_request(), 0, none);
		end

		for (int p = 0; p < 6; p++) begin
			drain();
			for (int k = 0; k < 6; k++) write_reg(3'(k), phase_cfg[p][k]);
			cfg_we <= 0;
			if (p == 5) quiet = 1;
			phase_items = (p == 0 || p == 4) ? 150 : 260;
			repeat (phase_items) send_request(random_request(), 0, none);
		end

		item_ch.valid <= 0;
		while (pending.size() != 0) @(negedge clk);
		repeat (300) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#1000000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
